[rtl/bmcf_pkg.sv]
// Package for the bit matrix column filter.
// Holds default sizes, action codes and status codes. No dependencies.
package bmcf_pkg;

  // Default matrix size.
  localparam int BMCF_MAX_ROWS = 64;
  localparam int BMCF_MAX_COLS = 64;

  // Action codes carried by each input transaction.
  localparam logic [2:0] ACT_RESIZE_ROWS = 3'd0;
  localparam logic [2:0] ACT_RESIZE_COLS = 3'd1;
  localparam logic [2:0] ACT_WRITE_CELL  = 3'd2;
  localparam logic [2:0] ACT_READ_CELL   = 3'd3;
  localparam logic [2:0] ACT_ROW_QUERY   = 3'd4;
  localparam logic [2:0] ACT_ADD_COL     = 3'd5;
  localparam logic [2:0] ACT_REMOVE_COL  = 3'd6;
  localparam logic [2:0] ACT_CLEAR_COL   = 3'd7;

  // Status codes returned with each result.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_SAT   = 2'd2;

endpackage

[rtl/bit_matrix_column_filter_top.sv]
// Bit matrix column filter. Count actions, rejected requests and resizes that do
// not shrink go straight to the result; in-range cell and row actions walk their
// one row, a row shrink walks the dropped rows, and column actions and a column
// shrink walk all MAX_ROWS rows, all by the single read-modify-write unit that walks
// the row memory one row a cycle. The input reopens as the result is loaded into the
// output register; it stays stalled while an earlier result waits on out_stall.
// Reset (synchronous, active low) clears the counts, then a clearing pass writes ones
// to every row while the input is stalled.
// Depends on bmcf_pkg.
module bit_matrix_column_filter_top #(
  parameter int MAX_ROWS = bmcf_pkg::BMCF_MAX_ROWS,
  parameter int MAX_COLS = bmcf_pkg::BMCF_MAX_COLS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [6:0] in_row_index,
  input  logic [6:0] in_col_index,
  input  logic       in_cell_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_bit,
  output logic [1:0] out_status
);
  import bmcf_pkg::*;

  // Widths: row pointer/count, row address, wide compare, column count, column bit.
  localparam int PW = $clog2(MAX_ROWS + 1);
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int XW = (PW > 7) ? PW : 7;
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int BW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Sequencer states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic [PW-1:0]       end_r, end_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       waddr_r, waddr_nxt;
  logic [2:0]          act_r, act_nxt;
  logic [6:0]          col_r, col_nxt;
  logic                val_r, val_nxt;
  logic                dowr_r, dowr_nxt;
  logic                bit_r, bit_nxt;
  logic [1:0]          sts_r, sts_nxt;
  logic [PW-1:0]       live_rows_r, live_rows_nxt;
  logic [CW-1:0]       live_cols_r, live_cols_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_bit_r, out_bit_nxt;
  logic [1:0]          out_sts_r, out_sts_nxt;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] mem_q_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [MAX_COLS-1:0] row_new;
  logic [MAX_COLS:0]   word_ext;

  logic                in_acc;
  logic [XW-1:0]       row_x;
  logic [XW-1:0]       live_rows_x;
  logic                row_ok;
  logic                col_ok;

  assign in_acc      = in_valid && !in_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign row_x       = XW'(in_row_index);
  assign live_rows_x = XW'(live_rows_r);
  assign row_ok      = row_x < live_rows_x;
  assign col_ok      = in_col_index < 7'(live_cols_r);

  // Row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[ptr_r[AW-1:0]];
  end

  // Shared modify unit: new row word from the word just read.
  assign word_ext = {1'b1, mem_q_r};
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      unique case (act_r)
        ACT_RESIZE_ROWS: row_new[i] = 1'b1;
        ACT_RESIZE_COLS: row_new[i] = mem_q_r[i] | !(7'(i) < col_r);
        ACT_WRITE_CELL:  row_new[i] = (7'(i) == col_r) ? val_r : mem_q_r[i];
        ACT_REMOVE_COL:  row_new[i] = (7'(i) < col_r) ? mem_q_r[i] : word_ext[i+1];
        ACT_CLEAR_COL:   row_new[i] = (7'(i) == col_r) ? 1'b1 : mem_q_r[i];
        default:         row_new[i] = mem_q_r[i];
      endcase
    end
  end

  // Memory write port select: clearing pass or the modify unit.
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_r[AW-1:0];
      mem_wdata = '1;
    end else begin
      mem_we    = (state_r == S_RUN) && pend_r && dowr_r;
      mem_waddr = waddr_r;
      mem_wdata = row_new;
    end
  end

  // Sequencer: clearing pass after reset, decode on accept, walk the rows, then hand off the result.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    pend_nxt      = 1'b0;
    waddr_nxt     = waddr_r;
    act_nxt       = act_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    dowr_nxt      = dowr_r;
    bit_nxt       = bit_r;
    sts_nxt       = sts_r;
    live_rows_nxt = live_rows_r;
    live_cols_nxt = live_cols_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bit_nxt   = out_bit_r;
    out_sts_nxt   = out_sts_r;

    unique case (state_r)
      S_CLEAR: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == PW'(MAX_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_action;
          col_nxt   = in_col_index;
          val_nxt   = in_cell_value;
          bit_nxt   = 1'b0;
          sts_nxt   = STS_OK;
          dowr_nxt  = 1'b1;
          state_nxt = S_DONE;
          unique case (in_action)
            ACT_RESIZE_ROWS: begin
              if (row_x > XW'(MAX_ROWS)) begin
                live_rows_nxt = PW'(MAX_ROWS);
                sts_nxt       = STS_SAT;
              end else begin
                live_rows_nxt = row_x[PW-1:0];
              end
              // Rows dropped by a shrink are filled with ones.
              if (live_rows_nxt < live_rows_r) begin
                ptr_nxt   = live_rows_nxt;
                end_nxt   = live_rows_r;
                state_nxt = S_RUN;
              end
            end
            ACT_RESIZE_COLS: begin
              if (in_col_index > 7'(MAX_COLS)) begin
                live_cols_nxt = CW'(MAX_COLS);
                sts_nxt       = STS_SAT;
              end else begin
                live_cols_nxt = in_col_index[CW-1:0];
              end
              col_nxt = 7'(live_cols_nxt);
              if (live_cols_nxt < live_cols_r) begin
                ptr_nxt   = '0;
                end_nxt   = PW'(MAX_ROWS);
                state_nxt = S_RUN;
              end
            end
            ACT_WRITE_CELL, ACT_READ_CELL: begin
              dowr_nxt = (in_action == ACT_WRITE_CELL);
              if (row_ok && col_ok) begin
                ptr_nxt   = row_x[PW-1:0];
                end_nxt   = row_x[PW-1:0] + 1'b1;
                state_nxt = S_RUN;
              end else begin
                sts_nxt = STS_RANGE;
              end
            end
            ACT_ROW_QUERY: begin
              dowr_nxt = 1'b0;
              if (row_ok) begin
                ptr_nxt   = row_x[PW-1:0];
                end_nxt   = row_x[PW-1:0] + 1'b1;
                state_nxt = S_RUN;
              end else begin
                bit_nxt = 1'b1;
                sts_nxt = STS_RANGE;
              end
            end
            ACT_ADD_COL: begin
              if (in_col_index > 7'(live_cols_r)) begin
                sts_nxt = STS_RANGE;
              end else if (live_cols_r == CW'(MAX_COLS)) begin
                sts_nxt = STS_SAT;
              end else begin
                live_cols_nxt = live_cols_r + 1'b1;
              end
            end
            ACT_REMOVE_COL, ACT_CLEAR_COL: begin
              if (col_ok) begin
                if (in_action == ACT_REMOVE_COL) begin
                  live_cols_nxt = live_cols_r - 1'b1;
                end
                ptr_nxt   = '0;
                end_nxt   = PW'(MAX_ROWS);
                state_nxt = S_RUN;
              end else begin
                sts_nxt = STS_RANGE;
              end
            end
            default: begin
              sts_nxt = STS_RANGE;
            end
          endcase
        end
      end

      S_RUN: begin
        // Issue the next row read while the previous row is modified.
        if (ptr_r < end_r) begin
          pend_nxt  = 1'b1;
          waddr_nxt = ptr_r[AW-1:0];
          ptr_nxt   = ptr_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
        if (pend_r) begin
          if (act_r == ACT_READ_CELL) begin
            bit_nxt = mem_q_r[col_r[BW-1:0]];
          end else if (act_r == ACT_ROW_QUERY) begin
            bit_nxt = &mem_q_r;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = bit_r;
          out_sts_nxt   = sts_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      end_r       <= '0;
      pend_r      <= 1'b0;
      live_rows_r <= '0;
      live_cols_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      end_r       <= end_nxt;
      pend_r      <= pend_nxt;
      live_rows_r <= live_rows_nxt;
      live_cols_r <= live_cols_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    waddr_r   <= waddr_nxt;
    act_r     <= act_nxt;
    col_r     <= col_nxt;
    val_r     <= val_nxt;
    dowr_r    <= dowr_nxt;
    bit_r     <= bit_nxt;
    sts_r     <= sts_nxt;
    out_bit_r <= out_bit_nxt;
    out_sts_r <= out_sts_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_result_bit = out_bit_r;
  assign out_status     = out_sts_r;

  // An accepted transaction always makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input accepted but block not busy afterwards");

  // Live counts never pass the matrix size.
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (live_rows_r <= PW'(MAX_ROWS)) && (live_cols_r <= CW'(MAX_COLS)))
    else $error("live count beyond matrix size");

  // The memory is written only by the clearing pass or the row walk.
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_RUN))
    else $error("row memory written outside a walk");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sts_r != 2'd3))
    else $error("undefined status code at output");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bit_matrix_column_filter_top: a directed table, then random actions.
// A local model of the matrix predicts each untyped result. Depends on bmcf_pkg and the top-level RTL.
module tb_top;
  import bmcf_pkg::*;

  localparam int NR = BMCF_MAX_ROWS;
  localparam int NC = BMCF_MAX_COLS;
  localparam int RAW = $clog2(NR);
  localparam int CAW = $clog2(NC);
  localparam int N_DIRECTED = 26;
  localparam int N_RANDOM = 1024;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic       result_bit;
    logic [1:0] status;
  } filter_result_t;

  typedef struct packed {
    logic [2:0] act;
    logic [6:0] row;
    logic [6:0] col;
    logic       val;
    logic       typed;
    logic       rbit;
    logic [1:0] sts;
  } directed_row_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_action = ACT_READ_CELL;
  logic [6:0] in_row_index = '0;
  logic [6:0] in_col_index = '0;
  logic       in_cell_value = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_result_bit;
  logic [1:0] out_status;

  // Local copy of the matrix and its live sizes.
  logic [NC-1:0]  model_rows [NR];
  logic [6:0]     model_live_rows;
  logic [6:0]     model_live_cols;

  filter_result_t pending_results [$];
  int             mismatch_count = 0;
  bit             long_hold_req = 1'b0;
  int             burst_left = 0;

  bit_matrix_column_filter_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result_bit(out_result_bit),
    .out_status    (out_status)
  );

  always #2 clk = ~clk;

  // Directed table. Rows with typed set carry an expectation read straight off the spec.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_READ_CELL,   7'd0,   7'd0,   1'b0, 1'b1, 1'b0, STS_RANGE},
    '{ACT_ROW_QUERY,   7'd0,   7'd0,   1'b0, 1'b1, 1'b1, STS_RANGE},
    '{ACT_REMOVE_COL,  7'd0,   7'd0,   1'b0, 1'b1, 1'b0, STS_RANGE},
    '{ACT_CLEAR_COL,   7'd0,   7'd0,   1'b0, 1'b1, 1'b0, STS_RANGE},
    '{ACT_ADD_COL,     7'd0,   7'd1,   1'b0, 1'b1, 1'b0, STS_RANGE},
    '{ACT_RESIZE_ROWS, 7'd127, 7'd0,   1'b0, 1'b1, 1'b0, STS_SAT},
    '{ACT_RESIZE_COLS, 7'd0,   7'd127, 1'b0, 1'b1, 1'b0, STS_SAT},
    '{ACT_ADD_COL,     7'd0,   7'd64,  1'b0, 1'b1, 1'b0, STS_SAT},
    '{ACT_WRITE_CELL,  7'd63,  7'd63,  1'b0, 1'b1, 1'b0, STS_OK},
    '{ACT_READ_CELL,   7'd63,  7'd63,  1'b0, 1'b1, 1'b0, STS_OK},
    '{ACT_ROW_QUERY,   7'd63,  7'd0,   1'b0, 1'b1, 1'b0, STS_OK},
    '{ACT_WRITE_CELL,  7'd64,  7'd0,   1'b1, 1'b1, 1'b0, STS_RANGE},
    '{ACT_READ_CELL,   7'd0,   7'd64,  1'b0, 1'b1, 1'b0, STS_RANGE},
    '{ACT_ROW_QUERY,   7'd64,  7'd0,   1'b0, 1'b1, 1'b1, STS_RANGE},
    '{ACT_CLEAR_COL,   7'd0,   7'd63,  1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_READ_CELL,   7'd63,  7'd63,  1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_WRITE_CELL,  7'd5,   7'd10,  1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_REMOVE_COL,  7'd0,   7'd3,   1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_READ_CELL,   7'd5,   7'd9,   1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_REMOVE_COL,  7'd0,   7'd62,  1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_RESIZE_COLS, 7'd0,   7'd8,   1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_RESIZE_COLS, 7'd0,   7'd64,  1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_RESIZE_ROWS, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_RESIZE_ROWS, 7'd64,  7'd0,   1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_RESIZE_COLS, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, STS_OK},
    '{ACT_ADD_COL,     7'd0,   7'd0,   1'b0, 1'b0, 1'b0, STS_OK}
  };

  // Mask of the columns below c, where c runs from 0 to the full width.
  function automatic logic [NC-1:0] cols_below(input logic [6:0] c);
    if (c >= NC) begin
      return '1;
    end
    return (({{(NC-1){1'b0}}, 1'b1}) << c) - 1'b1;
  endfunction

  // Applies one action to the local matrix and returns the result it should give.
  function automatic filter_result_t filter_apply(input logic [2:0] act, input logic [6:0] row,
                                                  input logic [6:0] col, input logic val);
    filter_result_t res;
    logic [6:0]     n;
    logic [NC-1:0]  w;
    logic [NC-1:0]  upper;
    int             r;
    res = '{result_bit: 1'b0, status: STS_OK};
    case (act)
      ACT_RESIZE_ROWS: begin
        n = row;
        if (n > NR) begin
          n = 7'(NR);
          res.status = STS_SAT;
        end
        for (r = n; r < model_live_rows && r < NR; r++) model_rows[r] = '1;
        model_live_rows = n;
      end
      ACT_RESIZE_COLS: begin
        n = col;
        if (n > NC) begin
          n = 7'(NC);
          res.status = STS_SAT;
        end
        if (n < model_live_cols) begin
          for (r = 0; r < NR; r++) model_rows[r] = model_rows[r] | ~cols_below(n);
        end
        model_live_cols = n;
      end
      ACT_WRITE_CELL: begin
        if (row < model_live_rows && col < model_live_cols) begin
          model_rows[row[RAW-1:0]][col[CAW-1:0]] = val;
        end else begin
          res.status = STS_RANGE;
        end
      end
      ACT_READ_CELL: begin
        if (row < model_live_rows && col < model_live_cols) begin
          res.result_bit = model_rows[row[RAW-1:0]][col[CAW-1:0]];
        end else begin
          res.status = STS_RANGE;
        end
      end
      ACT_ROW_QUERY: begin
        if (row < model_live_rows) begin
          res.result_bit = &model_rows[row[RAW-1:0]];
        end else begin
          res.result_bit = 1'b1;
          res.status = STS_RANGE;
        end
      end
      ACT_ADD_COL: begin
        if (col > model_live_cols) begin
          res.status = STS_RANGE;
        end else if (model_live_cols >= NC) begin
          res.status = STS_SAT;
        end else begin
          model_live_cols = model_live_cols + 1'b1;
        end
      end
      ACT_REMOVE_COL: begin
        if (col < model_live_cols) begin
          for (r = 0; r < NR; r++) begin
            w = model_rows[r];
            upper = '0;
            if (col + 1 < NC) upper = (w >> (col + 1)) << col;
            model_rows[r] = (w & cols_below(col)) | upper;
            model_rows[r][NC-1] = 1'b1;
          end
          model_live_cols = model_live_cols - 1'b1;
        end else begin
          res.status = STS_RANGE;
        end
      end
      default: begin
        if (col < model_live_cols) begin
          for (r = 0; r < NR; r++) model_rows[r][col[CAW-1:0]] = 1'b1;
        end else begin
          res.status = STS_RANGE;
        end
      end
    endcase
    return res;
  endfunction

  // Index mostly inside the live area, sometimes on its edge or anywhere in the field.
  function automatic logic [6:0] pick_index(input logic [6:0] live);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80 && live > 0) return 7'($urandom_range(0, live - 1));
    if (sel < 90) return live;
    return 7'($urandom_range(0, 127));
  endfunction

  // Size mostly large, sometimes small, sometimes past the maximum.
  function automatic logic [6:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 7'($urandom_range(32, 64));
    if (sel < 85) return 7'($urandom_range(0, 31));
    return 7'($urandom_range(65, 127));
  endfunction

  // Offers one transaction and records its expected result once it is accepted.
  task automatic offer_action(input logic [2:0] act, input logic [6:0] row, input logic [6:0] col,
                              input logic val, input logic typed, input logic tbit,
                              input logic [1:0] tsts);
    filter_result_t res;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_row_index  <= row;
    in_col_index  <= col;
    in_cell_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = filter_apply(act, row, col, val);
    if (typed) begin
      res = '{result_bit: tbit, status: tsts};
    end
    pending_results.push_back(res);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // Reset, then the directed table, then random actions, then the drain.
  initial begin
    logic [2:0] act;
    logic [6:0] row;
    logic [6:0] col;
    logic       val;
    int         sel;
    int         i;
    for (i = 0; i < NR; i++) model_rows[i] = '1;
    model_live_rows = '0;
    model_live_cols = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      offer_action(directed_rows[i].act, directed_rows[i].row, directed_rows[i].col,
                   directed_rows[i].val, directed_rows[i].typed, directed_rows[i].rbit,
                   directed_rows[i].sts);
      pace_sender();
    end

    for (i = 0; i < N_RANDOM; i++) begin
      // Ask the receiver for a long hold-off while items keep coming.
      if (i == 300) long_hold_req = 1'b1;
      // Pause the sender until every result is back.
      if (i == 650) begin
        in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      row = pick_index(model_live_rows);
      col = pick_index(model_live_cols);
      val = ($urandom_range(0, 9) < 7);
      if (sel < 25) begin
        act = ACT_WRITE_CELL;
      end else if (sel < 50) begin
        act = ACT_READ_CELL;
      end else if (sel < 62) begin
        act = ACT_ROW_QUERY;
      end else if (sel < 68) begin
        act = ACT_RESIZE_ROWS;
        row = pick_size();
      end else if (sel < 74) begin
        act = ACT_RESIZE_COLS;
        col = pick_size();
      end else if (sel < 82) begin
        act = ACT_ADD_COL;
        if ($urandom_range(0, 9) < 8) col = 7'($urandom_range(0, model_live_cols));
      end else if (sel < 91) begin
        act = ACT_REMOVE_COL;
      end else begin
        act = ACT_CLEAR_COL;
      end
      offer_action(act, row, col, val, 1'b0, 1'b0, STS_OK);
      pace_sender();
    end

    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (NR + 16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off counted here on request.
  initial begin
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       phase;
    logic     stall_next;
    mode = RX_FREE;
    seg_left = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (mode)
          RX_FREE:     stall_next = 1'b0;
          RX_RANDOM:   stall_next = 1'($urandom_range(0, 1));
          RX_PERIODIC: stall_next = (phase % 4 == 3);
          default:     stall_next = ($urandom_range(0, 3) != 0);
        endcase
        out_stall <= stall_next;
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    filter_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, result_bit %0d status %0d", $time,
                 out_result_bit, out_status);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_result_bit !== exp_res.result_bit) begin
          $display("%0t: result_bit mismatch, expected %0d actual %0d", $time,
                   exp_res.result_bit, out_result_bit);
          mismatch_count++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   exp_res.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
